### rtl/arpc_pkg.sv
// shared constants and types for the arp address cache
package arpc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int IP_W    = 32;
	localparam int MAC_W   = 48;
	localparam int STAMP_W = 32;
	localparam int SLOT_W  = 4;

	localparam logic REQ_LEARN  = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [IP_W-1:0]    ip;
		logic [MAC_W-1:0]   mac;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic             found;
		idx_t             match_idx;
		logic [MAC_W-1:0] match_mac;
		logic             free_found;
		idx_t             free_idx;
		idx_t             best_idx;
	} scan_result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

### rtl/arpc_table.sv
// binding table: entry storage with one read port, one write port and valid bits
module arpc_table (
	input  logic               clk,
	input  logic               arst_n,
	input  arpc_pkg::idx_t     rd_idx,
	output arpc_pkg::entry_t   rd_entry,
	output logic               rd_valid,
	input  logic               wr_en,
	input  arpc_pkg::idx_t     wr_idx,
	input  arpc_pkg::entry_t   wr_entry
);

	arpc_pkg::entry_t               entry_q [arpc_pkg::ENTRIES];
	logic [arpc_pkg::ENTRIES-1:0]   valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_idx] <= wr_entry;
		end
	end

	assign rd_entry = entry_q[rd_idx];
	assign rd_valid = valid_q[rd_idx];

endmodule

### rtl/arpc_scan.sv
// shared compare unit: one entry per step, tracks first match, first free and oldest stamp
module arpc_scan (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              init,
	input  logic                              step,
	input  logic [arpc_pkg::IP_W-1:0]         ip,
	input  arpc_pkg::idx_t                    idx,
	input  arpc_pkg::entry_t                  entry,
	input  logic                              entry_valid,
	output arpc_pkg::scan_result_t            result
);

	arpc_pkg::scan_result_t          res_q;
	logic [arpc_pkg::STAMP_W-1:0]    best_stamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q        <= '0;
			best_stamp_q <= '1;
		end else if (init) begin
			res_q        <= '0;
			best_stamp_q <= '1;
		end else if (step) begin
			if (!res_q.found && entry_valid && entry.ip == ip) begin
				res_q.found     <= 1'b1;
				res_q.match_idx <= idx;
				res_q.match_mac <= entry.mac;
			end
			if (!res_q.free_found && !entry_valid) begin
				res_q.free_found <= 1'b1;
				res_q.free_idx   <= idx;
			end
			// strict less keeps the lowest index on equal stamps
			if (entry_valid && entry.stamp < best_stamp_q) begin
				res_q.best_idx <= idx;
				best_stamp_q   <= entry.stamp;
			end
		end
	end

	assign result = res_q;

endmodule

### rtl/arpc_sequencer.sv
// sequencer: walks the table through the compare unit, then writes back and reports
module arpc_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           req_type,
	input  logic [arpc_pkg::IP_W-1:0]      ip_addr,
	input  logic [arpc_pkg::MAC_W-1:0]     mac_addr,
	output arpc_pkg::idx_t                 rd_idx,
	output logic                           scan_init,
	output logic                           scan_step,
	output logic [arpc_pkg::IP_W-1:0]      scan_ip,
	input  arpc_pkg::scan_result_t         scan_res,
	output logic                           wr_en,
	output arpc_pkg::idx_t                 wr_idx,
	output arpc_pkg::entry_t               wr_entry,
	output logic                           done,
	output logic                           hit,
	output logic [arpc_pkg::MAC_W-1:0]     mac_out,
	output logic [arpc_pkg::SLOT_W-1:0]    slot
);

	localparam arpc_pkg::idx_t LAST = arpc_pkg::IDX_W'(arpc_pkg::ENTRIES - 1);

	arpc_pkg::state_t                state_q, state_d;
	arpc_pkg::idx_t                  idx_q;
	logic                            req_q;
	logic [arpc_pkg::IP_W-1:0]       ip_q;
	logic [arpc_pkg::MAC_W-1:0]      mac_q;
	logic [arpc_pkg::STAMP_W-1:0]    stamp_ctr_q;
	logic                            done_q;
	logic                            hit_q;
	logic [arpc_pkg::MAC_W-1:0]      mac_out_q;
	logic [arpc_pkg::SLOT_W-1:0]     slot_q;
	logic                            accept;
	logic                            finish;
	arpc_pkg::idx_t                  sel_idx;
	logic [arpc_pkg::MAC_W-1:0]      mac_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		accept    = 1'b0;
		finish    = 1'b0;
		scan_step = 1'b0;
		unique case (state_q)
			arpc_pkg::ST_IDLE: begin
				if (start) begin
					accept  = 1'b1;
					state_d = arpc_pkg::ST_SCAN;
				end
			end
			arpc_pkg::ST_SCAN: begin
				scan_step = 1'b1;
				if (idx_q == LAST) begin
					state_d = arpc_pkg::ST_FINISH;
				end
			end
			arpc_pkg::ST_FINISH: begin
				finish  = 1'b1;
				state_d = arpc_pkg::ST_IDLE;
			end
			default: state_d = arpc_pkg::ST_IDLE;
		endcase
	end

	assign busy      = (state_q != arpc_pkg::ST_IDLE);
	assign scan_init = accept;
	assign scan_ip   = ip_q;
	assign rd_idx    = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			stamp_ctr_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= finish;
			if (accept) begin
				idx_q <= '0;
			end else if (scan_step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (finish && req_q == arpc_pkg::REQ_LEARN) begin
				stamp_ctr_q <= stamp_ctr_q + 1'b1;
			end
		end
	end

	// request fields held for the whole walk
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			ip_q  <= ip_addr;
			mac_q <= mac_addr;
		end
	end

	always_comb begin
		priority if (scan_res.found) begin
			sel_idx = scan_res.match_idx;
		end else if (req_q == arpc_pkg::REQ_LOOKUP) begin
			sel_idx = '0;
		end else if (scan_res.free_found) begin
			sel_idx = scan_res.free_idx;
		end else begin
			sel_idx = scan_res.best_idx;
		end
	end

	assign mac_res = (req_q == arpc_pkg::REQ_LOOKUP && scan_res.found) ?
		scan_res.match_mac : '0;

	assign wr_en          = finish && (req_q == arpc_pkg::REQ_LEARN);
	assign wr_idx         = sel_idx;
	assign wr_entry.ip    = ip_q;
	assign wr_entry.mac   = mac_q;
	assign wr_entry.stamp = stamp_ctr_q;

	always_ff @(posedge clk) begin
		if (finish) begin
			hit_q     <= scan_res.found;
			mac_out_q <= mac_res;
			slot_q    <= arpc_pkg::SLOT_W'(sel_idx);
		end
	end

	assign done    = done_q;
	assign hit     = hit_q;
	assign mac_out = mac_out_q;
	assign slot    = slot_q;

endmodule

### rtl/arp_address_cache_core.sv
// top level of the arp address cache: table of ipv4 to mac bindings
//
// request channel: drive req_type, ip_addr and mac_addr with start high; the
// transfer happens at a rising edge where start is high and busy is low.
// req_type 0 learns a binding, 1 looks one up.
// result channel: done is high for exactly one cycle with hit, mac_out and
// slot valid in that cycle; the receiver must take it, there is no stall.
// sequence: after the accepting edge busy stays high while the scan state
// walks the table one entry per cycle through a single compare unit (address
// match, first free slot, oldest stamp) and the finish state then writes back
// a learn and registers the result. done follows in the next cycle, which is
// also the first cycle a new start is taken; no request is taken while busy.
// the walk length equals the table depth, set by the single read port.
// reset clears all valid bits and the stamp counter at once; the table is
// usable in the first cycle after reset is released.
module arp_address_cache_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           req_type,
	input  logic [arpc_pkg::IP_W-1:0]      ip_addr,
	input  logic [arpc_pkg::MAC_W-1:0]     mac_addr,
	output logic                           done,
	output logic                           hit,
	output logic [arpc_pkg::MAC_W-1:0]     mac_out,
	output logic [arpc_pkg::SLOT_W-1:0]    slot
);

	arpc_pkg::idx_t                  rd_idx;
	arpc_pkg::entry_t                rd_entry;
	logic                            rd_valid;
	logic                            wr_en;
	arpc_pkg::idx_t                  wr_idx;
	arpc_pkg::entry_t                wr_entry;
	logic                            scan_init;
	logic                            scan_step;
	logic [arpc_pkg::IP_W-1:0]       scan_ip;
	arpc_pkg::scan_result_t          scan_res;

	arpc_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (rd_idx),
		.rd_entry (rd_entry),
		.rd_valid (rd_valid),
		.wr_en    (wr_en),
		.wr_idx   (wr_idx),
		.wr_entry (wr_entry)
	);

	arpc_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.init        (scan_init),
		.step        (scan_step),
		.ip          (scan_ip),
		.idx         (rd_idx),
		.entry       (rd_entry),
		.entry_valid (rd_valid),
		.result      (scan_res)
	);

	arpc_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.ip_addr   (ip_addr),
		.mac_addr  (mac_addr),
		.rd_idx    (rd_idx),
		.scan_init (scan_init),
		.scan_step (scan_step),
		.scan_ip   (scan_ip),
		.scan_res  (scan_res),
		.wr_en     (wr_en),
		.wr_idx    (wr_idx),
		.wr_entry  (wr_entry),
		.done      (done),
		.hit       (hit),
		.mac_out   (mac_out),
		.slot      (slot)
	);

endmodule

### bench/tb_top.sv
// self-checking testbench for the arp address cache core
module tb_top;

	typedef struct packed {
		logic                       hit;
		logic [arpc_pkg::MAC_W-1:0] mac;
		logic [arpc_pkg::SLOT_W-1:0] slot;
	} reply_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic                        req_type = arpc_pkg::REQ_LEARN;
	logic [arpc_pkg::IP_W-1:0]   ip_addr = '0;
	logic [arpc_pkg::MAC_W-1:0]  mac_addr = '0;
	logic                        done;
	logic                        hit;
	logic [arpc_pkg::MAC_W-1:0]  mac_out;
	logic [arpc_pkg::SLOT_W-1:0] slot;

	// shadow copy of the binding table
	logic [arpc_pkg::IP_W-1:0]    bind_ip [arpc_pkg::ENTRIES];
	logic [arpc_pkg::MAC_W-1:0]   bind_mac [arpc_pkg::ENTRIES];
	logic                         bind_valid [arpc_pkg::ENTRIES];
	logic [arpc_pkg::STAMP_W-1:0] bind_stamp [arpc_pkg::ENTRIES];
	logic [arpc_pkg::STAMP_W-1:0] learn_stamp;

	reply_t pending_replies[$];
	reply_t want;
	int     errors = 0;
	bit     idling_on = 1'b1;

	arp_address_cache_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.ip_addr  (ip_addr),
		.mac_addr (mac_addr),
		.done     (done),
		.hit      (hit),
		.mac_out  (mac_out),
		.slot     (slot)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	function automatic void clear_bindings();
		for (int i = 0; i < arpc_pkg::ENTRIES; i++) begin
			bind_ip[i]    = '0;
			bind_mac[i]   = '0;
			bind_valid[i] = 1'b0;
			bind_stamp[i] = '0;
		end
		learn_stamp = '0;
	endfunction

	// applies one request to the shadow table and returns the reply it must give
	function automatic reply_t cache_apply(input logic kind,
			input logic [arpc_pkg::IP_W-1:0] ip, input logic [arpc_pkg::MAC_W-1:0] mac);
		reply_t                       r;
		int                           found;
		int                           victim;
		int                           target;
		logic [arpc_pkg::STAMP_W-1:0] oldest;
		r = '0;
		found = -1;
		for (int i = 0; i < arpc_pkg::ENTRIES; i++)
			if (found < 0 && bind_valid[i] && bind_ip[i] == ip)
				found = i;
		r.hit = (found >= 0);
		if (kind == arpc_pkg::REQ_LEARN) begin
			if (found >= 0) begin
				target = found;
			end else begin
				// first free slot wins, else the oldest stamp, lowest index on ties
				victim = -1;
				target = 0;
				oldest = '1;
				for (int i = 0; i < arpc_pkg::ENTRIES; i++) begin
					if (victim < 0 && !bind_valid[i])
						victim = i;
					if (bind_stamp[i] < oldest) begin
						oldest = bind_stamp[i];
						target = i;
					end
				end
				if (victim >= 0)
					target = victim;
				bind_ip[target]    = ip;
				bind_valid[target] = 1'b1;
			end
			bind_mac[target]   = mac;
			bind_stamp[target] = learn_stamp;
			learn_stamp        = learn_stamp + 1'b1;
			r.slot = target[arpc_pkg::SLOT_W-1:0];
		end else if (found >= 0) begin
			r.slot = found[arpc_pkg::SLOT_W-1:0];
			r.mac  = bind_mac[found];
		end
		return r;
	endfunction

	// optional idle burst, then one request held until it is taken
	task automatic send_req(input logic kind, input logic [arpc_pkg::IP_W-1:0] ip,
			input logic [arpc_pkg::MAC_W-1:0] mac);
		int gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start    <= 1'b1;
		req_type <= kind;
		ip_addr  <= ip;
		mac_addr <= mac;
		do
			@(posedge clk);
		while (busy);
		pending_replies.push_back(cache_apply(kind, ip, mac));
		@(negedge clk);
	endtask

	task automatic drain_replies();
		start <= 1'b0;
		while (pending_replies.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [arpc_pkg::MAC_W-1:0] rand_mac();
		logic [arpc_pkg::MAC_W-1:0] m;
		m[31:0]  = $urandom();
		m[47:32] = 16'($urandom());
		return m;
	endfunction

	task automatic test_basics();
		// empty table: lookups of ip zero and all ones must not match invalid entries
		send_req(arpc_pkg::REQ_LOOKUP, 32'h0000_0000, '1);
		send_req(arpc_pkg::REQ_LOOKUP, 32'hffff_ffff, '0);
		send_req(arpc_pkg::REQ_LEARN, 32'h0000_0000, '0);
		send_req(arpc_pkg::REQ_LEARN, 32'hffff_ffff, '1);
		send_req(arpc_pkg::REQ_LOOKUP, 32'h0000_0000, 48'h1234_5678_9abc);
		send_req(arpc_pkg::REQ_LOOKUP, 32'hffff_ffff, '0);
		// refresh of an existing binding
		send_req(arpc_pkg::REQ_LEARN, 32'hffff_ffff, 48'h5555_5555_5555);
		send_req(arpc_pkg::REQ_LOOKUP, 32'hffff_ffff, '1);
		send_req(arpc_pkg::REQ_LOOKUP, 32'h0000_0001, '0);
		send_req(arpc_pkg::REQ_LEARN, 32'haaaa_aaaa, 48'haaaa_aaaa_aaaa);
		send_req(arpc_pkg::REQ_LOOKUP, 32'h5555_5555, '0);
		send_req(arpc_pkg::REQ_LOOKUP, 32'haaaa_aaaa, '0);
		drain_replies();
	endtask

	task automatic test_eviction();
		// fill the table, then force replacement of the oldest entries
		for (int i = 3; i < arpc_pkg::ENTRIES; i++)
			send_req(arpc_pkg::REQ_LEARN, 32'h0a00_0000 + i, rand_mac());
		send_req(arpc_pkg::REQ_LEARN, 32'h0000_0000, rand_mac());
		send_req(arpc_pkg::REQ_LEARN, 32'hc0a8_0001, rand_mac());
		send_req(arpc_pkg::REQ_LEARN, 32'hc0a8_0002, rand_mac());
		send_req(arpc_pkg::REQ_LOOKUP, 32'hffff_ffff, '0);
		send_req(arpc_pkg::REQ_LOOKUP, 32'haaaa_aaaa, '0);
		send_req(arpc_pkg::REQ_LEARN, 32'hc0a8_0003, rand_mac());
		send_req(arpc_pkg::REQ_LOOKUP, 32'h0a00_0003, '0);
		drain_replies();
	endtask

	task automatic test_random(input int count, input int pool_size, input bit idle);
		logic [arpc_pkg::IP_W-1:0] ip_pool[$];
		logic [arpc_pkg::IP_W-1:0] ip;
		logic                      kind;
		idling_on = idle;
		for (int i = 0; i < pool_size; i++)
			ip_pool.push_back($urandom());
		ip_pool.push_back(32'h0000_0000);
		ip_pool.push_back(32'hffff_ffff);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) < 8)
				ip = ip_pool[$urandom_range(0, ip_pool.size() - 1)];
			else
				ip = $urandom();
			kind = $urandom_range(0, 1) ? arpc_pkg::REQ_LOOKUP : arpc_pkg::REQ_LEARN;
			send_req(kind, ip, rand_mac());
		end
		drain_replies();
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("result strobe with no request outstanding");
			end else begin
				want = pending_replies.pop_front();
				if (hit !== want.hit)
					report_mismatch($sformatf("hit %b, expected %b", hit, want.hit));
				if (mac_out !== want.mac)
					report_mismatch($sformatf("mac_out %h, expected %h", mac_out, want.mac));
				if (slot !== want.slot)
					report_mismatch($sformatf("slot %0d, expected %0d", slot, want.slot));
			end
		end
	end

	initial begin
		clear_bindings();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_basics();
		test_eviction();
		test_random(600, 6, 1'b1);
		test_random(600, 40, 1'b1);
		test_random(620, 20, 1'b0);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
rtl/arpc_pkg.sv
rtl/arpc_table.sv
rtl/arpc_scan.sv
rtl/arpc_sequencer.sv
rtl/arp_address_cache_core.sv
bench/tb_top.sv
